[src/kdslp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the key debounce / press detector.
// Used by kdslp_engine, key_debounce_short_long_press and kdslp_checker.
package kdslp_pkg;

  localparam int unsigned KeyW   = 7;
  localparam int unsigned KeyIdW = 3;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] CountMax     = 16'hFFFF;
  localparam logic [CountW-1:0] DebounceRst  = 16'd2;
  localparam logic [CountW-1:0] LongPressRst = 16'd100;

  // action field
  localparam logic ActTick = 1'b0;
  localparam logic ActRead = 1'b1;

  // configuration register indexes
  localparam logic CfgDebounce  = 1'b0;
  localparam logic CfgLongPress = 1'b1;

  // key ids (0 = none)
  localparam logic [KeyIdW-1:0] KeyNone  = 3'd0;
  localparam logic [KeyIdW-1:0] KeyUp    = 3'd1;
  localparam logic [KeyIdW-1:0] KeyDown  = 3'd2;
  localparam logic [KeyIdW-1:0] KeyLeft  = 3'd3;
  localparam logic [KeyIdW-1:0] KeyRight = 3'd4;
  localparam logic [KeyIdW-1:0] KeyOk    = 3'd5;
  localparam logic [KeyIdW-1:0] KeyBack  = 3'd6;
  localparam logic [KeyIdW-1:0] KeyRun   = 3'd7;

  // event codes; short events share the key id value
  localparam logic [CodeW-1:0] EvNone     = 4'd0;
  localparam logic [CodeW-1:0] EvLongUp   = 4'd8;
  localparam logic [CodeW-1:0] EvLongDown = 4'd9;
  localparam logic [CodeW-1:0] EvLongOk   = 4'd10;
  localparam logic [CodeW-1:0] EvLongRun  = 4'd11;

  typedef struct packed {
    logic [CodeW-1:0]  event_code;
    logic [KeyIdW-1:0] key_id;
    logic [KeyW-1:0]   stable_keys;
  } result_t;

  // priority pick of the lowest pressed key
  function automatic logic [KeyIdW-1:0] lowest_key(input logic [KeyW-1:0] mask);
    logic [KeyIdW-1:0] k;
    k = KeyNone;
    for (int i = KeyW - 1; i >= 0; i--) begin
      if (mask[i]) k = KeyIdW'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [CodeW-1:0] long_code(input logic [KeyIdW-1:0] key);
    logic [CodeW-1:0] c;
    case (key)
      KeyUp:   c = EvLongUp;
      KeyDown: c = EvLongDown;
      KeyOk:   c = EvLongOk;
      KeyRun:  c = EvLongRun;
      default: c = EvNone;
    endcase
    return c;
  endfunction

endpackage

[src/kdslp_engine.sv]
`timescale 1ns / 1ps
// Debounce, press tracking and event mailbox state with its one-pass update.
// Depends on kdslp_pkg.
module kdslp_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           action_i,
  input  logic [kdslp_pkg::KeyW-1:0]     key_mask_i,
  input  logic [kdslp_pkg::CountW-1:0]   debounce_count_i,
  input  logic [kdslp_pkg::CountW-1:0]   long_press_count_i,
  output kdslp_pkg::result_t             result_o
);

  logic [kdslp_pkg::KeyW-1:0]   last_raw_q, last_raw_d;
  logic [kdslp_pkg::CountW-1:0] deb_cnt_q, deb_cnt_d;
  logic [kdslp_pkg::KeyW-1:0]   stable_q, stable_d;
  logic [kdslp_pkg::CountW-1:0] press_cnt_q, press_cnt_d;
  logic                         long_given_q, long_given_d;
  logic [kdslp_pkg::KeyIdW-1:0] held_q, held_d;
  logic [kdslp_pkg::CodeW-1:0]  pending_q, pending_d;
  logic [kdslp_pkg::CodeW-1:0]  post_code;
  logic [kdslp_pkg::CodeW-1:0]  ev_code;

  always_comb begin
    last_raw_d   = last_raw_q;
    deb_cnt_d    = deb_cnt_q;
    stable_d     = stable_q;
    press_cnt_d  = press_cnt_q;
    long_given_d = long_given_q;
    held_d       = held_q;
    pending_d    = pending_q;
    post_code    = kdslp_pkg::EvNone;
    ev_code      = kdslp_pkg::EvNone;

    if (action_i == kdslp_pkg::ActRead) begin
      ev_code   = pending_q;
      pending_d = kdslp_pkg::EvNone;
    end else begin
      if (key_mask_i == last_raw_q) begin
        if (deb_cnt_q < debounce_count_i) deb_cnt_d = deb_cnt_q + 1'b1;
      end else begin
        deb_cnt_d  = '0;
        last_raw_d = key_mask_i;
      end

      if (!(deb_cnt_d < debounce_count_i)) begin
        if (stable_q != key_mask_i) begin
          if (stable_q != '0 && key_mask_i == '0) begin
            // release: short event unless the long stage was reached
            if (!long_given_q) post_code = kdslp_pkg::CodeW'(held_q);
            press_cnt_d  = '0;
            long_given_d = 1'b0;
            held_d       = kdslp_pkg::KeyNone;
          end else if (stable_q == '0) begin
            held_d       = kdslp_pkg::lowest_key(key_mask_i);
            press_cnt_d  = '0;
            long_given_d = 1'b0;
          end
          stable_d = key_mask_i;
        end

        if (held_d != kdslp_pkg::KeyNone && stable_d != '0) begin
          if (press_cnt_d != kdslp_pkg::CountMax) press_cnt_d = press_cnt_d + 1'b1;
          if (press_cnt_d >= long_press_count_i && !long_given_d) begin
            post_code    = kdslp_pkg::long_code(held_d);
            long_given_d = 1'b1;
          end
        end
      end

      // single-slot mailbox, drop while full
      if (post_code != kdslp_pkg::EvNone && pending_q == kdslp_pkg::EvNone) begin
        pending_d = post_code;
      end
    end
  end

  assign result_o.event_code  = ev_code;
  assign result_o.key_id      = held_d;
  assign result_o.stable_keys = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q   <= '0;
      deb_cnt_q    <= '0;
      stable_q     <= '0;
      press_cnt_q  <= '0;
      long_given_q <= 1'b0;
      held_q       <= kdslp_pkg::KeyNone;
      pending_q    <= kdslp_pkg::EvNone;
    end else if (step_i) begin
      last_raw_q   <= last_raw_d;
      deb_cnt_q    <= deb_cnt_d;
      stable_q     <= stable_d;
      press_cnt_q  <= press_cnt_d;
      long_given_q <= long_given_d;
      held_q       <= held_d;
      pending_q    <= pending_d;
    end
  end

endmodule

[src/key_debounce_short_long_press.sv]
`timescale 1ns / 1ps
// Top level of the seven-key debounce and short/long press detector.
// Depends on kdslp_pkg and kdslp_engine.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one beat is either a tick
//   (action_i = 0) carrying the sampled key mask, or a read (action_i = 1)
//   that returns and clears the pending event; key_mask_i is ignored on a read.
//   Output channel (out_valid_o / out_stall_i): exactly one result beat per
//   input beat, in order: event_code_o (read only, else 0), key_id_o and
//   stable_keys_o as they stand after that beat.
//   Config channel (cfg_valid_i / cfg_ready_o): index 0 debounce count,
//   index 1 long press count; write only while no beat is in flight.
//   cfg_ready_o is always high.
// Path: an accepted input beat is captured in the input register, then one
//   pass of update logic moves its result into the output register once
//   that register is free or draining.
// Throughput: one beat per cycle while out_stall_i holds no result; the state update is a single pass of
//   compares and 16-bit increments, so consecutive beats chain directly.
// Reset: all state clears, no key held, mailbox empty, debounce count 2,
//   long press count 100; both valid flags drop.
// Stall: while a result waits under out_stall_i the input register holds,
//   and in_stall_o rises only when that register is also occupied.
module key_debounce_short_long_press (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [kdslp_pkg::KeyW-1:0]    key_mask_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kdslp_pkg::CodeW-1:0]   event_code_o,
  output logic [kdslp_pkg::KeyIdW-1:0]  key_id_o,
  output logic [kdslp_pkg::KeyW-1:0]    stable_keys_o,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [kdslp_pkg::CountW-1:0]  cfg_data_i
);

  // config registers
  logic [kdslp_pkg::CountW-1:0] debounce_q, long_press_q;

  // input register
  logic                         in_vld_q;
  logic                         action_q;
  logic [kdslp_pkg::KeyW-1:0]   mask_q;

  // output register
  logic                         out_vld_q;
  kdslp_pkg::result_t           res_q, res_d;

  logic advance;
  logic in_load;

  // the input register moves on whenever the output register is free or drains
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= kdslp_pkg::DebounceRst;
      long_press_q <= kdslp_pkg::LongPressRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kdslp_pkg::CfgDebounce:  debounce_q   <= cfg_data_i;
        kdslp_pkg::CfgLongPress: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      action_q <= action_i;
      mask_q   <= key_mask_i;
    end
  end

  kdslp_engine u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .action_i           (action_q),
    .key_mask_i         (mask_q),
    .debounce_count_i   (debounce_q),
    .long_press_count_i (long_press_q),
    .result_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_valid_o   = out_vld_q;
  assign event_code_o  = res_q.event_code;
  assign key_id_o      = res_q.key_id;
  assign stable_keys_o = res_q.stable_keys;

endmodule

[src/kdslp_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for key_debounce_short_long_press, plus its bind.
// Depends on kdslp_pkg.
module kdslp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input logic [kdslp_pkg::CodeW-1:0]   event_code_i,
  input logic [kdslp_pkg::KeyIdW-1:0]  key_id_i,
  input logic [kdslp_pkg::KeyW-1:0]    stable_keys_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(event_code_i)
      && $stable(key_id_i) && $stable(stable_keys_i))
    else $error("stalled result changed");

  // a held key exists exactly when the debounced mask is non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((key_id_i == kdslp_pkg::KeyNone) == (stable_keys_i == '0)))
    else $error("held key and stable mask disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_code_i <= kdslp_pkg::EvLongRun)
    else $error("event code out of range");

  // input backpressure only while a result is waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind key_debounce_short_long_press kdslp_checker u_kdslp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .event_code_i  (event_code_o),
  .key_id_i      (key_id_o),
  .stable_keys_i (stable_keys_o)
);

[tb/key_debounce_short_long_press_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for key_debounce_short_long_press: directed table, then
// random press sequences, an extreme-setting check and a no-gap run.
// Depends on kdslp_pkg and the RTL.
module key_debounce_short_long_press_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 10;

  // DUT ports
  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          action_i;
  logic [kdslp_pkg::KeyW-1:0]    key_mask_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [kdslp_pkg::CodeW-1:0]   event_code_o;
  logic [kdslp_pkg::KeyIdW-1:0]  key_id_o;
  logic [kdslp_pkg::KeyW-1:0]    stable_keys_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic                          cfg_index_i;
  logic [kdslp_pkg::CountW-1:0]  cfg_data_i;

  key_debounce_short_long_press u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_mask_i   (key_mask_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_code_o (event_code_o),
    .key_id_o     (key_id_o),
    .stable_keys_o(stable_keys_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Directed table row: either a config pair or one input beat. A row with
  // typed set carries its expected report; all others use the predictor.
  typedef struct packed {
    logic                          is_cfg;
    logic                          act;
    logic [kdslp_pkg::KeyW-1:0]    mask;
    logic [kdslp_pkg::CountW-1:0]  settle;
    logic [kdslp_pkg::CountW-1:0]  long_thr;
    logic                          typed;
    kdslp_pkg::result_t            exp;
  } dir_row_t;

  // Predictor copy of the block: config and press-tracking state.
  logic [kdslp_pkg::CountW-1:0]  cfg_settle;
  logic [kdslp_pkg::CountW-1:0]  cfg_long;
  logic [kdslp_pkg::KeyW-1:0]    raw_seen;
  logic [kdslp_pkg::CountW-1:0]  settle_cnt;
  logic [kdslp_pkg::KeyW-1:0]    steady_mask;
  logic [kdslp_pkg::CountW-1:0]  hold_ticks;
  logic                          long_hit;
  logic [kdslp_pkg::KeyIdW-1:0]  cur_key;
  logic [kdslp_pkg::CodeW-1:0]   mailbox;

  kdslp_pkg::result_t keypad_report_q[$];   // reports owed by the block, oldest first

  // Handshake flags, sampled at the falling edge where everything is settled.
  bit in_fire;
  bit cfg_fire;

  // Driver side tags on the beat currently offered.
  logic               cur_typed;
  kdslp_pkg::result_t cur_exp;

  bit          gaps_on;
  int unsigned n_beats;
  int unsigned n_reports;
  int unsigned n_cfg;
  int unsigned n_short;
  int unsigned n_long;
  int unsigned mismatch_cnt;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [kdslp_pkg::KeyIdW-1:0] first_pressed(
      input logic [kdslp_pkg::KeyW-1:0] mask);
    logic [kdslp_pkg::KeyIdW-1:0] id;
    id = kdslp_pkg::KeyNone;
    for (int i = 0; i < kdslp_pkg::KeyW; i++) begin
      if (id == kdslp_pkg::KeyNone && mask[i]) id = kdslp_pkg::KeyIdW'(i + 1);
    end
    return id;
  endfunction

  function automatic logic [kdslp_pkg::CodeW-1:0] long_event_of(
      input logic [kdslp_pkg::KeyIdW-1:0] id);
    case (id)
      kdslp_pkg::KeyUp:   return kdslp_pkg::EvLongUp;
      kdslp_pkg::KeyDown: return kdslp_pkg::EvLongDown;
      kdslp_pkg::KeyOk:   return kdslp_pkg::EvLongOk;
      kdslp_pkg::KeyRun:  return kdslp_pkg::EvLongRun;
      default:            return kdslp_pkg::EvNone;
    endcase
  endfunction

  // mailbox holds one event; anything posted while it is full is lost
  function automatic void post_event(input logic [kdslp_pkg::CodeW-1:0] code);
    if (code != kdslp_pkg::EvNone && mailbox == kdslp_pkg::EvNone) mailbox = code;
  endfunction

  // Advance the predicted state by one accepted beat, return the report it owes.
  function automatic kdslp_pkg::result_t press_detect_step(
      input logic act, input logic [kdslp_pkg::KeyW-1:0] mask);
    kdslp_pkg::result_t r;
    r.event_code = kdslp_pkg::EvNone;
    if (act == kdslp_pkg::ActRead) begin
      // read: key_mask is don't-care, only the mailbox moves
      r.event_code = mailbox;
      mailbox = kdslp_pkg::EvNone;
    end else begin
      if (mask == raw_seen) begin
        if (settle_cnt < cfg_settle) settle_cnt = settle_cnt + 1'b1;
      end else begin
        settle_cnt = '0;
        raw_seen = mask;
      end
      if (settle_cnt >= cfg_settle) begin
        if (steady_mask != mask) begin
          if (steady_mask != '0 && mask == '0) begin
            // release: short event only if the long stage was never reached
            if (!long_hit) post_event(kdslp_pkg::CodeW'(cur_key));
            hold_ticks = '0;
            long_hit = 1'b0;
            cur_key = kdslp_pkg::KeyNone;
          end else if (steady_mask == '0 && mask != '0) begin
            cur_key = first_pressed(mask);
            hold_ticks = '0;
            long_hit = 1'b0;
          end
          // non-empty to non-empty: mask follows, held key stays
          steady_mask = mask;
        end
        if (cur_key != kdslp_pkg::KeyNone && steady_mask != '0) begin
          if (hold_ticks != kdslp_pkg::CountMax) hold_ticks = hold_ticks + 1'b1;
          if (hold_ticks >= cfg_long && !long_hit) begin
            // left/right/back reach the long stage silently
            post_event(long_event_of(cur_key));
            long_hit = 1'b1;
          end
        end
      end
    end
    r.key_id = cur_key;
    r.stable_keys = steady_mask;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and receiver stall
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side backpressure: ~35% stall while gaps are enabled.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= gaps_on && rst_ni && ($urandom_range(0, 99) < 35);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard, at the falling edge: inputs are driven at the
  // rising edge and outputs are registered, so both are stable here.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : monitor
    kdslp_pkg::result_t got;
    kdslp_pkg::result_t want;
    if (!rst_ni) begin
      in_fire  = 1'b0;
      cfg_fire = 1'b0;
    end else begin
      in_fire  = in_valid_i && !in_stall_o;
      cfg_fire = cfg_valid_i && cfg_ready_o;
      if (cfg_fire) begin
        if (cfg_index_i == kdslp_pkg::CfgDebounce) cfg_settle = cfg_data_i;
        else cfg_long = cfg_data_i;
      end
      if (in_fire) begin
        want = press_detect_step(action_i, key_mask_i);
        if (cur_typed) want = cur_exp;
        keypad_report_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        got = {event_code_o, key_id_o, stable_keys_o};
        n_reports++;
        if (got.event_code >= kdslp_pkg::EvLongUp) n_long++;
        else if (got.event_code != kdslp_pkg::EvNone) n_short++;
        if (keypad_report_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected report beat: event %0d key %0d stable %h",
                     $realtime, got.event_code, got.key_id, got.stable_keys);
        end else begin
          want = keypad_report_q.pop_front();
          if (got.event_code !== want.event_code || got.key_id !== want.key_id ||
              got.stable_keys !== want.stable_keys) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: report %0d mismatch: event %0d/%0d key %0d/%0d ",
                        "stable %h/%h (exp/act)"},
                       $realtime, n_reports, want.event_code, got.event_code,
                       want.key_id, got.key_id, want.stable_keys, got.stable_keys);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks; all called right after a rising edge
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until accepted. Valid stays high on return so
  // back-to-back beats need no extra assignment.
  task automatic send_beat(input logic act, input logic [kdslp_pkg::KeyW-1:0] mask,
                           input logic typed, input kdslp_pkg::result_t exp);
    if (gaps_on && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 35);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_mask_i <= mask;
    cur_typed  <= typed;
    cur_exp    <= exp;
    do @(posedge clk_i); while (!in_fire);
    n_beats++;
  endtask

  task automatic tick(input logic [kdslp_pkg::KeyW-1:0] mask);
    send_beat(kdslp_pkg::ActTick, mask, 1'b0, '0);
  endtask

  // read with a random don't-care mask
  task automatic read_event();
    send_beat(kdslp_pkg::ActRead, kdslp_pkg::KeyW'($urandom), 1'b0, '0);
  endtask

  // Stop sending and wait until every owed report has come out. Each beat
  // yields exactly one report, so an empty queue means the block is idle.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (keypad_report_q.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back, only from idle.
  task automatic set_config(input logic [kdslp_pkg::CountW-1:0] settle,
                            input logic [kdslp_pkg::CountW-1:0] long_thr);
    wait_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= kdslp_pkg::CfgDebounce;
    cfg_data_i  <= settle;
    do @(posedge clk_i); while (!cfg_fire);
    cfg_index_i <= kdslp_pkg::CfgLongPress;
    cfg_data_i  <= long_thr;
    do @(posedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
    n_cfg += 2;
  endtask

  // One press: a key chord held past debounce with bounce, chord changes and
  // reads mixed in, then a clean release and usually a read.
  task automatic press_seq(input int unsigned settle, input int unsigned long_thr);
    logic [kdslp_pkg::KeyW-1:0] m;
    int unsigned hold;
    int unsigned rel;
    int unsigned r;
    m = $urandom_range(0, 1) ?
        kdslp_pkg::KeyW'(1 << $urandom_range(0, kdslp_pkg::KeyW - 1)) :
        kdslp_pkg::KeyW'($urandom_range(1, 127));
    hold = settle + $urandom_range(0, long_thr + 4);
    rel = settle + 1 + $urandom_range(0, 2);
    for (int unsigned i = 0; i < hold; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) read_event();
      else if (r < 14) tick(kdslp_pkg::KeyW'($urandom_range(0, 127)));   // bounce
      else begin
        if (r < 18) m = kdslp_pkg::KeyW'($urandom_range(1, 127));       // chord change
        tick(m);
      end
    end
    for (int unsigned i = 0; i < rel; i++) tick('0);
    if ($urandom_range(0, 9) < 7) read_event();
  endtask

  // Random phase: mostly well-formed presses, some raw noise.
  task automatic run_random(input int unsigned n, input int unsigned settle,
                            input int unsigned long_thr, input bit hold_off);
    int unsigned start;
    int unsigned k;
    bit paused;
    start = n_beats;
    paused = 1'b0;
    while (n_beats - start < n) begin
      if (hold_off && !paused && n_beats - start >= n / 2) begin
        wait_results();   // let the block run dry mid-phase
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) press_seq(settle, long_thr);
      else begin
        k = $urandom_range(1, 4);
        repeat (k) send_beat(logic'($urandom_range(0, 1)),
                             kdslp_pkg::KeyW'($urandom), 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d reports still owed", cyc, keypad_report_q.size());
    $display("key_debounce_short_long_press regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    dir_row_t dir_tab[$];
    dir_row_t row;
    kdslp_pkg::result_t idle_rep;
    int unsigned settle_list[7];
    int unsigned long_list[7];

    // all inputs known from time zero
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = kdslp_pkg::ActTick;
    key_mask_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = kdslp_pkg::CfgDebounce;
    cfg_data_i  = '0;
    cur_typed   = 1'b0;
    cur_exp     = '0;
    gaps_on     = 1'b1;

    // predictor reset state
    cfg_settle  = kdslp_pkg::DebounceRst;
    cfg_long    = kdslp_pkg::LongPressRst;
    raw_seen    = '0;
    settle_cnt  = '0;
    steady_mask = '0;
    hold_ticks  = '0;
    long_hit    = 1'b0;
    cur_key     = kdslp_pkg::KeyNone;
    mailbox     = kdslp_pkg::EvNone;

    n_beats = 0; n_reports = 0; n_cfg = 0; n_short = 0; n_long = 0; mismatch_cnt = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // -------------------------------------------------------------------------
    // Directed table. Nothing held, empty mailbox: the idle report.
    // -------------------------------------------------------------------------
    idle_rep = {kdslp_pkg::EvNone, kdslp_pkg::KeyNone, 7'h00};
    // reset config (debounce 2, long 100): read of empty mailbox, then two
    // ticks of all keys that are still settling
    dir_tab.push_back({1'b0, kdslp_pkg::ActRead, 7'h7F, 16'd0, 16'd0, 1'b1, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h7F, 16'd0, 16'd0, 1'b1, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h7F, 16'd0, 16'd0, 1'b1, idle_rep});
    // accepted, up held
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h7F, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    // release, short up
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActRead, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    // zero debounce, threshold 1: back reaches long stage silently, no short
    dir_tab.push_back({1'b1, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd1, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h20, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActRead, 7'h00, 16'd0, 16'd0, 1'b1, idle_rep});
    // long ok, chord change ok->ok+run keeps ok held, then run's long event
    // is lost on the full mailbox; the read mask is ignored
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h10, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h50, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h40, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActRead, 7'h7F, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActRead, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    // zero long threshold: long down on the very first held tick
    dir_tab.push_back({1'b1, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h02, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActRead, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    // short right under threshold 3
    dir_tab.push_back({1'b1, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd3, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h08, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h08, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActTick, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});
    dir_tab.push_back({1'b0, kdslp_pkg::ActRead, 7'h00, 16'd0, 16'd0, 1'b0, idle_rep});

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) set_config(row.settle, row.long_thr);
      else send_beat(row.act, row.mask, row.typed, row.exp);
    end

    // -------------------------------------------------------------------------
    // Random phases over a spread of small settings; the last one is drawn
    // at random. One phase pauses mid-way until the block is empty.
    // -------------------------------------------------------------------------
    settle_list = '{1, 2, 0, 4, 3, 0, 0};
    long_list   = '{3, 6, 1, 12, 2, 5, 1};
    settle_list[6] = $urandom_range(0, 5);
    long_list[6]   = $urandom_range(1, 20);
    for (int p = 0; p < 7; p++) begin
      set_config(kdslp_pkg::CountW'(settle_list[p]), kdslp_pkg::CountW'(long_list[p]));
      run_random(55, settle_list[p], long_list[p], p == 3);
    end

    // -------------------------------------------------------------------------
    // No gaps on either side: largest debounce and threshold, where a steady
    // key never settles within a few ticks, then a back-to-back random run.
    // -------------------------------------------------------------------------
    gaps_on = 1'b0;
    set_config(kdslp_pkg::CountMax, kdslp_pkg::CountMax);
    repeat (6) tick(kdslp_pkg::KeyW'(1 << (kdslp_pkg::KeyUp - 1)));
    read_event();
    set_config('0, 16'd4);
    run_random(60, 0, 4, 1'b0);
    gaps_on = 1'b1;

    // back to a small setting for a short tail with gaps
    set_config(16'd1, 16'd2);
    run_random(30, 1, 2, 1'b0);

    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    mismatch_cnt += keypad_report_q.size();

    $display("covered %0d input beats and %0d report beats over %0d config writes",
             n_beats, n_reports, n_cfg);
    $display("events read back: %0d short, %0d long; %0d mismatches",
             n_short, n_long, mismatch_cnt);
    if (mismatch_cnt == 0) $display("key_debounce_short_long_press regression: pass");
    else $display("key_debounce_short_long_press regression: fail");
    $finish;
  end

endmodule
